// File: rtl/core/json_path_query_tokenizer_assert.svh
// Assertion macros for the path query tokenizer checker.
// No dependencies; included by the checker file.
`ifndef JSON_PATH_QUERY_TOKENIZER_ASSERT_SVH
`define JSON_PATH_QUERY_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define JPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jpq assertion failed");

// next-cycle implication
`define JPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jpq assertion failed");

`endif

// File: rtl/core/jpq_pkg.sv
// Shared types and constants for the path query tokenizer.
// No dependencies.
package jpq_pkg;

	localparam int MAX_NAME_LEN = 15;
	localparam int NAME_LEN_W   = $clog2(MAX_NAME_LEN + 1);
	localparam int INDEX_W      = 31;
	localparam int CHAR_W       = 8;
	localparam int KIND_W       = 3;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [KIND_W-1:0] TK_ROOT  = 3'd0;
	localparam logic [KIND_W-1:0] TK_MCHAR = 3'd1;
	localparam logic [KIND_W-1:0] TK_MEND  = 3'd2;
	localparam logic [KIND_W-1:0] TK_ELEM  = 3'd3;
	localparam logic [KIND_W-1:0] TK_ERR   = 3'd4;
	localparam logic [KIND_W-1:0] TK_DONE  = 3'd5;

	// one queued item: a token, optionally followed by a member-end token
	typedef struct packed {
		logic               pair;
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
		logic               last;
	} jpq_entry_t;

endpackage

// File: rtl/core/jpq_front.sv
// Lexer front end: accepts characters and classifies them into queue entries.
// Depends on jpq_pkg.
module jpq_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [jpq_pkg::CHAR_W-1:0] in_char,
	input  logic                       in_last,
	input  logic                       q_full,
	output logic                       in_ready,
	output logic                       push,
	output jpq_pkg::jpq_entry_t        push_entry
);

	localparam logic [2:0] ST_EXPECT_ACTION  = 3'd0;
	localparam logic [2:0] ST_EXPECT_INDEX   = 3'd1;
	localparam logic [2:0] ST_EXPECT_MEMBER  = 3'd2;
	localparam logic [2:0] ST_READING_INDEX  = 3'd3;
	localparam logic [2:0] ST_READING_MEMBER = 3'd4;
	localparam logic [2:0] ST_EXPECT_CLOSE   = 3'd5;
	localparam logic [2:0] ST_ERROR          = 3'd6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [jpq_pkg::INDEX_W+3:0] INDEX_MAX =
		{4'b0, {jpq_pkg::INDEX_W{1'b1}}};

	logic [2:0]                       state_q, state_d;
	logic [jpq_pkg::INDEX_W-1:0]      acc_q, acc_d;
	logic [jpq_pkg::NAME_LEN_W-1:0]   len_q, len_d;
	logic                             accept;
	logic                             is_digit, is_alnum;
	logic [jpq_pkg::INDEX_W+3:0]      acc_sum;
	logic [jpq_pkg::INDEX_W-1:0]      acc_next;
	logic                             emit;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	assign is_digit = (in_char >= 8'h30) && (in_char <= 8'h39);
	assign is_alnum = is_digit || ((in_char >= 8'h41) && (in_char <= 8'h5A))
		|| ((in_char >= 8'h61) && (in_char <= 8'h7A));

	// acc * 10 + digit, saturating
	assign acc_sum = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0}
		+ {{(jpq_pkg::INDEX_W){1'b0}}, in_char[3:0]};
	assign acc_next = (acc_sum > INDEX_MAX) ? {jpq_pkg::INDEX_W{1'b1}}
		: acc_sum[jpq_pkg::INDEX_W-1:0];

	always_comb begin
		state_d         = state_q;
		acc_d           = acc_q;
		len_d           = len_q;
		emit            = 1'b0;
		push_entry.pair = 1'b0;
		push_entry.kind = jpq_pkg::TK_DONE;
		push_entry.ch   = '0;
		push_entry.idx  = '0;
		push_entry.last = in_last;
		case (state_q)
			ST_EXPECT_ACTION: begin
				if (in_char == CH_DOLLAR) begin
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ROOT;
				end else if (in_char == CH_DOT) begin
					state_d = ST_EXPECT_MEMBER;
					len_d   = '0;
				end else if (in_char == CH_LBRACK) begin
					state_d = ST_EXPECT_INDEX;
					acc_d   = '0;
				end else if (in_char != CH_SPACE) begin
					state_d         = ST_ERROR;
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ERR;
				end
			end
			ST_EXPECT_INDEX: begin
				if (is_digit) begin
					state_d = ST_READING_INDEX;
					acc_d   = {{(jpq_pkg::INDEX_W-4){1'b0}}, in_char[3:0]};
				end else if (in_char != CH_SPACE) begin
					state_d         = ST_ERROR;
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ERR;
				end
			end
			ST_READING_INDEX: begin
				if (is_digit) begin
					acc_d = acc_next;
				end else if (in_char == CH_SPACE || in_char == CH_RBRACK) begin
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ELEM;
					push_entry.idx  = acc_q;
					state_d = (in_char == CH_SPACE) ? ST_EXPECT_CLOSE : ST_EXPECT_ACTION;
				end else begin
					state_d         = ST_ERROR;
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ERR;
				end
			end
			ST_EXPECT_CLOSE: begin
				if (in_char == CH_RBRACK) begin
					state_d = ST_EXPECT_ACTION;
				end else if (in_char != CH_SPACE) begin
					state_d         = ST_ERROR;
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ERR;
				end
			end
			ST_EXPECT_MEMBER: begin
				if (is_alnum) begin
					state_d         = ST_READING_MEMBER;
					len_d           = {{(jpq_pkg::NAME_LEN_W-1){1'b0}}, 1'b1};
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_MCHAR;
					push_entry.ch   = in_char;
					push_entry.pair = in_last;
				end else if (in_char != CH_SPACE) begin
					state_d         = ST_ERROR;
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ERR;
				end
			end
			ST_READING_MEMBER: begin
				if (is_alnum) begin
					if (len_q >= jpq_pkg::NAME_LEN_W'(jpq_pkg::MAX_NAME_LEN)) begin
						state_d         = ST_ERROR;
						emit            = 1'b1;
						push_entry.kind = jpq_pkg::TK_ERR;
					end else begin
						len_d           = len_q + 1'b1;
						emit            = 1'b1;
						push_entry.kind = jpq_pkg::TK_MCHAR;
						push_entry.ch   = in_char;
						push_entry.pair = in_last;
					end
				end else if (in_char == CH_SPACE || in_char == CH_DOT
						|| in_char == CH_LBRACK) begin
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_MEND;
					if (in_char == CH_DOT) begin
						state_d = ST_EXPECT_MEMBER;
						len_d   = '0;
					end else if (in_char == CH_LBRACK) begin
						state_d = ST_EXPECT_INDEX;
						acc_d   = '0;
					end else begin
						state_d = ST_EXPECT_ACTION;
					end
				end else begin
					state_d         = ST_ERROR;
					emit            = 1'b1;
					push_entry.kind = jpq_pkg::TK_ERR;
				end
			end
			default: begin
				state_d = ST_ERROR;
			end
		endcase
		if (in_last) begin
			emit    = 1'b1;
			state_d = ST_EXPECT_ACTION;
			acc_d   = '0;
			len_d   = '0;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXPECT_ACTION;
			acc_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			state_q <= state_d;
			acc_q   <= acc_d;
			len_q   <= len_d;
		end
	end

endmodule

// File: rtl/core/jpq_queue.sv
// Short queue between lexer front end and token back end.
// Depends on jpq_pkg.
module jpq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jpq_pkg::jpq_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output jpq_pkg::jpq_entry_t head
);

	jpq_pkg::jpq_entry_t              mem_q [jpq_pkg::QUEUE_DEPTH];
	logic [jpq_pkg::QPTR_W-1:0]       wr_q, rd_q;
	logic [jpq_pkg::QPTR_W:0]         count_q;

	assign full      = (count_q == (jpq_pkg::QPTR_W+1)'(jpq_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/jpq_back.sv
// Token back end: expands queue entries into result items on the output register.
// Depends on jpq_pkg.
module jpq_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_not_empty,
	input  jpq_pkg::jpq_entry_t          q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [jpq_pkg::KIND_W-1:0]   out_kind,
	output logic [jpq_pkg::CHAR_W-1:0]   out_char,
	output logic [jpq_pkg::INDEX_W-1:0]  out_index,
	output logic                         out_last_run,
	output logic                         out_query_end
);

	logic valid_q, pend_q, pend_last_q;
	logic load;

	assign load  = !valid_q || out_ready;
	assign q_pop = load && !pend_q && q_not_empty;

	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (q_not_empty) begin
				valid_q     <= 1'b1;
				pend_q      <= q_head.pair;
				pend_last_q <= q_head.last;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_kind      <= jpq_pkg::TK_MEND;
				out_char      <= '0;
				out_index     <= '0;
				out_last_run  <= 1'b1;
				out_query_end <= pend_last_q;
			end else if (q_not_empty) begin
				out_kind      <= q_head.kind;
				out_char      <= q_head.ch;
				out_index     <= q_head.idx;
				out_last_run  <= !q_head.pair;
				out_query_end <= q_head.last && !q_head.pair;
			end
		end
	end

endmodule

// File: rtl/core/json_path_query_tokenizer.sv
// Path query tokenizer: one character in per cycle while the queue has room, tokens out
// over a stream port. Results pass from the queue into the output register.
// Throughput: one character per cycle while the 4-entry queue has room; a character
// giving two results sends them in turn, one per cycle while m_tready is high.
// Reset: arst_n asynchronously clears lexer state, queue pointers and output valid.
// Depends on jpq_pkg, jpq_front, jpq_queue and jpq_back.
module json_path_query_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // is_last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] name_char, [38:8] element_index, [39] zero
	output logic [3:0]  m_tuser,   // [2:0] token_kind, [3] query_end
	output logic        m_tlast    // last_of_run
);

	logic                          push, pop, q_full, q_not_empty;
	jpq_pkg::jpq_entry_t           push_entry, q_head;
	logic [jpq_pkg::KIND_W-1:0]    out_kind;
	logic [jpq_pkg::CHAR_W-1:0]    out_char;
	logic [jpq_pkg::INDEX_W-1:0]   out_index;
	logic                          out_query_end;

	jpq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_char    (s_tdata),
		.in_last    (s_tlast),
		.q_full     (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	jpq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	jpq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.q_pop         (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_kind      (out_kind),
		.out_char      (out_char),
		.out_index     (out_index),
		.out_last_run  (m_tlast),
		.out_query_end (out_query_end)
	);

	assign m_tdata = {1'b0, out_index, out_char};
	assign m_tuser = {out_query_end, out_kind};

endmodule

// File: rtl/core/jpq_checker.sv
// Port-level checker for the path query tokenizer, bound to the top level.
// Depends on jpq_pkg and json_path_query_tokenizer_assert.svh.
`include "json_path_query_tokenizer_assert.svh"

module jpq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	`JPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	`JPQ_ASSERT_NOW(a_end_on_last, clk, arst_n, m_tvalid && m_tuser[3], m_tlast)

	`JPQ_ASSERT_NOW(a_pair_is_mchar, clk, arst_n, m_tvalid && !m_tlast, m_tuser[2:0] == jpq_pkg::TK_MCHAR)

	`JPQ_ASSERT_NOW(a_char_zero, clk, arst_n, m_tvalid && m_tuser[2:0] != jpq_pkg::TK_MCHAR, m_tdata[7:0] == 8'h00)

	`JPQ_ASSERT_NOW(a_index_zero, clk, arst_n, m_tvalid && m_tuser[2:0] != jpq_pkg::TK_ELEM, m_tdata[39:8] == 32'h0)

endmodule

bind json_path_query_tokenizer jpq_checker u_jpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
